[hdl/sedt_pkg.sv]
// ----------------------------------------------------------------------------
// sedt_pkg
// Shared widths, register indexes, reset values and the gradient record
// passed from the window stage to the magnitude stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sedt_pkg;

   localparam int PIX_W     = 8;
   localparam int CFG_W     = 12;
   localparam int THR_W     = 11;
   localparam int ROW_W     = 13;
   localparam int SUM_W     = 10;
   localparam int PROD_W    = 20;
   localparam int GRAD_W    = 11;
   localparam int SQ_W      = 20;
   localparam int MAG_W     = 21;
   localparam int LIM_W     = 24;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_THRESHOLD = 2'd2;

   localparam logic [CFG_W-1:0] RST_WIDTH     = 12'd640;
   localparam logic [CFG_W-1:0] RST_HEIGHT    = 12'd480;
   localparam logic [THR_W-1:0] RST_THRESHOLD = 11'd100;

   // x / 3 == (x * 683) >> 11 for every x below 2048
   localparam logic [SUM_W-1:0] GREY_RECIP = 10'd683;
   localparam int               GREY_SHIFT = 11;

   typedef struct packed {
      logic signed [GRAD_W-1:0] gx;
      logic signed [GRAD_W-1:0] gy;
      logic [PIX_W-1:0]         centre;
      logic                     last;
   } grad_type;

endpackage

[hdl/sedt_mag.sv]
// ----------------------------------------------------------------------------
// sedt_mag
// Squares the Sobel gradients, compares gx^2 + gy^2 against the squared
// limit and holds the result in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sedt_mag (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  sedt_pkg::grad_type            in_grad,
   input  logic [sedt_pkg::LIM_W-1:0]    lim_sq,
   output logic                          in_free,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_edge_res,
   output logic [sedt_pkg::PIX_W-1:0]    rsp_grey_level,
   output logic                          rsp_frame_end
);
   import sedt_pkg::*;

   logic                        a_v_ff, a_v_in;
   grad_type                    a_grad_ff;
   logic                        b_v_ff, b_v_in;
   logic [SQ_W-1:0]             b_gx_sq_ff, b_gy_sq_ff;
   logic [PIX_W-1:0]            b_centre_ff;
   logic                        b_last_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_edge_ff;
   logic [PIX_W-1:0]            rsp_grey_ff;
   logic                        rsp_end_ff;

   logic                        out_free, b_free, b_move, a_move;
   logic signed [2*GRAD_W-1:0]  gx_prod, gy_prod;
   logic [MAG_W-1:0]            mag2;
   logic                        is_edge;

   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      b_move       = b_v_ff && out_free;
      b_free       = !b_v_ff || out_free;
      a_move       = a_v_ff && b_free;
      in_free      = !a_v_ff || b_free;
      a_v_in       = in_valid || (a_v_ff && !a_move);
      b_v_in       = a_move || (b_v_ff && !out_free);
      rsp_valid_in = b_move || (rsp_valid_ff && rsp_stall);
   end

   assign gx_prod = a_grad_ff.gx * a_grad_ff.gx;
   assign gy_prod = a_grad_ff.gy * a_grad_ff.gy;
   assign mag2    = MAG_W'(b_gx_sq_ff) + MAG_W'(b_gy_sq_ff);
   assign is_edge = LIM_W'(mag2) >= lim_sq;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff       <= 1'b0;
         b_v_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_v_ff       <= a_v_in;
         b_v_ff       <= b_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         a_grad_ff <= in_grad;
      end
      if (a_move) begin
         b_gx_sq_ff  <= gx_prod[SQ_W-1:0];
         b_gy_sq_ff  <= gy_prod[SQ_W-1:0];
         b_centre_ff <= a_grad_ff.centre;
         b_last_ff   <= a_grad_ff.last;
      end
      if (b_move) begin
         rsp_edge_ff <= is_edge;
         rsp_grey_ff <= b_centre_ff;
         rsp_end_ff  <= b_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_res   = rsp_edge_ff;
   assign rsp_grey_level = rsp_grey_ff;
   assign rsp_frame_end  = rsp_end_ff;

endmodule

[hdl/sobel_edge_threshold.sv]
// ----------------------------------------------------------------------------
// sobel_edge_threshold: streaming 3x3 Sobel edge detector with a threshold
// One item per cycle while req_stall is low; a result leaves through stage 1, magnitude stages a and b
// and the output register after the transfer that releases it (input k releases pixel k-width-1),
// paced by the line memory's one read-modify-write per cycle. Reset: 640x480, threshold 100, pipeline empty;
// line memory is not cleared.
`timescale 1ns / 1ps

module sobel_edge_threshold #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_op,
   input  logic [sedt_pkg::PIX_W-1:0]        req_red,
   input  logic [sedt_pkg::PIX_W-1:0]        req_green,
   input  logic [sedt_pkg::PIX_W-1:0]        req_blue,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_edge_res,
   output logic [sedt_pkg::PIX_W-1:0]        rsp_grey_level,
   output logic                              rsp_frame_end,
   input  logic                              csr_we,
   input  logic [sedt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sedt_pkg::CFG_W-1:0]        csr_wdata
);
   import sedt_pkg::*;

   localparam int                AW        = $clog2(MAX_WIDTH);
   localparam int                WCMP_W    = CFG_W + 2;
   localparam logic [WCMP_W-1:0] MAX_W_CMP = WCMP_W'(MAX_WIDTH);
   localparam int                MEM_W     = 2 * PIX_W;
   localparam int                TAP_W     = PIX_W + 2;

   // configuration
   logic [CFG_W-1:0]  width_ff, width_in;
   logic [CFG_W-1:0]  height_ff, height_in;
   logic [THR_W-1:0]  thr_ff, thr_in;
   logic [LIM_W-1:0]  lim_sq_ff;
   logic [CFG_W-1:0]  thr_p1;
   logic [CFG_W-1:0]  w_eff, h_eff;

   // raster position of the next input
   logic [AW-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;

   // accept side
   logic              req_fire, input_done, ignore, item, flush;
   logic [SUM_W-1:0]  pix_sum;
   logic [PROD_W-1:0] grey_prod;
   logic [PIX_W-1:0]  grey_calc, grey_pix;
   logic [ROW_W-1:0]  h_ext;
   logic              m0, m1, col_zero, due, last, col_wrap;

   // stage 1: line memory data is back
   logic              s1_v_ff, s1_v_in;
   logic [AW-1:0]     s1_c_ff;
   logic [PIX_W-1:0]  s1_grey_ff;
   logic              s1_m0_ff, s1_m1_ff, s1_czero_ff, s1_due_ff, s1_last_ff;
   logic              s1_adv, s1_free;

   // line memory: upper row in the high byte, lower row in the low byte
   logic [MEM_W-1:0]  line_mem [MAX_WIDTH];
   logic [MEM_W-1:0]  ram_q_ff;
   logic              byp_ff;
   logic [MEM_W-1:0]  byp_data_ff;
   logic [MEM_W-1:0]  mem_q, wr_data;
   logic [PIX_W-1:0]  up_rd, lo_rd;

   // window, [column left..right][row top..bottom]
   logic [PIX_W-1:0]  win_ff [3][3];
   logic [PIX_W-1:0]  tcol [3];
   logic [PIX_W-1:0]  ccol [3];
   logic [TAP_W-1:0]  gx_left, gx_right, gy_top, gy_bot;

   grad_type          mag_grad;
   logic              mag_valid, mag_free;

   // effective frame size
   always_comb begin
      if (width_ff == '0) begin
         w_eff = CFG_W'(1);
      end else if (WCMP_W'(width_ff) > MAX_W_CMP) begin
         w_eff = CFG_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      h_eff  = (height_ff == '0) ? CFG_W'(1) : height_ff;
      h_ext  = ROW_W'(h_eff);
      thr_p1 = CFG_W'(thr_ff) + CFG_W'(1);
   end

   // accept side decode
   always_comb begin
      req_fire   = req_valid && !req_stall;
      input_done = row_ff >= h_ext;
      ignore     = req_op && !input_done;
      item       = req_fire && !ignore;
      flush      = req_op || input_done;
      pix_sum    = SUM_W'(req_red) + SUM_W'(req_green) + SUM_W'(req_blue);
      grey_prod  = PROD_W'(pix_sum) * PROD_W'(GREY_RECIP);
      grey_calc  = PIX_W'(grey_prod >> GREY_SHIFT);
      grey_pix   = flush ? '0 : grey_calc;
      m0         = (row_ff >= ROW_W'(2)) && (row_ff < h_ext + ROW_W'(2));
      m1         = (row_ff >= ROW_W'(1)) && (row_ff < h_ext + ROW_W'(1));
      col_zero   = col_ff == '0;
      due        = (row_ff >= ROW_W'(2)) || ((row_ff == ROW_W'(1)) && !col_zero);
      // bottom-right pixel comes out at column 0 two rows past the last one
      last       = col_zero && (row_ff == h_ext + ROW_W'(1));
      col_wrap   = (WCMP_W'(col_ff) + WCMP_W'(1)) >= WCMP_W'(w_eff);
   end

   // position and configuration next state
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      thr_in    = thr_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_in = csr_wdata;
               col_in   = '0;
               row_in   = '0;
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = csr_wdata;
               col_in    = '0;
               row_in    = '0;
            end
            CSR_EDGE_THRESHOLD: begin
               thr_in = csr_wdata[THR_W-1:0];
            end
            default: begin
            end
         endcase
      end else if (item) begin
         if (last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_wrap) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
   end

   // stage 1 handshake, items that give no result skip the magnitude stages
   always_comb begin
      s1_adv    = s1_v_ff && (!s1_due_ff || mag_free);
      s1_free   = !s1_v_ff || s1_adv;
      req_stall = !s1_free;
      s1_v_in   = item || (s1_v_ff && !s1_adv);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_WIDTH;
         height_ff <= RST_HEIGHT;
         thr_ff    <= RST_THRESHOLD;
         col_ff    <= '0;
         row_ff    <= '0;
         s1_v_ff   <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         thr_ff    <= thr_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         s1_v_ff   <= s1_v_in;
      end
   end

   always_ff @(posedge clock) begin
      lim_sq_ff <= LIM_W'(thr_p1) * LIM_W'(thr_p1);
      if (item) begin
         s1_c_ff     <= col_ff;
         s1_grey_ff  <= grey_pix;
         s1_m0_ff    <= m0;
         s1_m1_ff    <= m1;
         s1_czero_ff <= col_zero;
         s1_due_ff   <= due;
         s1_last_ff  <= last;
      end
   end

   // read-modify-write of the line memory; same-column write in the read cycle is forwarded
   always_comb begin
      mem_q   = byp_ff ? byp_data_ff : ram_q_ff;
      up_rd   = mem_q[MEM_W-1:PIX_W];
      lo_rd   = mem_q[PIX_W-1:0];
      wr_data = {lo_rd, s1_grey_ff};
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         line_mem[s1_c_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (item) begin
         ram_q_ff <= line_mem[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (item) begin
         byp_ff      <= s1_adv && (s1_c_ff == col_ff);
         byp_data_ff <= wr_data;
      end
   end

   // new column, rows outside the image masked to zero
   always_comb begin
      tcol[0] = s1_m0_ff ? up_rd : '0;
      tcol[1] = s1_m1_ff ? lo_rd : '0;
      tcol[2] = s1_grey_ff;
      for (int i = 0; i < 3; i++) begin
         // column 0 sees the zero right border of the previous row
         ccol[i] = s1_czero_ff ? '0 : tcol[i];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[0][i] <= s1_czero_ff ? '0 : win_ff[1][i];
            win_ff[1][i] <= s1_czero_ff ? '0 : win_ff[2][i];
            win_ff[2][i] <= tcol[i];
         end
      end
   end

   // gradients over the shifted window: old middle, old right, new column
   always_comb begin
      gx_left  = TAP_W'(win_ff[1][0]) + {1'b0, win_ff[1][1], 1'b0} + TAP_W'(win_ff[1][2]);
      gx_right = TAP_W'(ccol[0]) + {1'b0, ccol[1], 1'b0} + TAP_W'(ccol[2]);
      gy_top   = TAP_W'(win_ff[1][0]) + {1'b0, win_ff[2][0], 1'b0} + TAP_W'(ccol[0]);
      gy_bot   = TAP_W'(win_ff[1][2]) + {1'b0, win_ff[2][2], 1'b0} + TAP_W'(ccol[2]);
      mag_grad.gx     = $signed({1'b0, gx_left}) - $signed({1'b0, gx_right});
      mag_grad.gy     = $signed({1'b0, gy_top}) - $signed({1'b0, gy_bot});
      mag_grad.centre = win_ff[2][1];
      mag_grad.last   = s1_last_ff;
      mag_valid       = s1_adv && s1_due_ff;
   end

   sedt_mag u_mag (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (mag_valid),
      .in_grad        (mag_grad),
      .lim_sq         (lim_sq_ff),
      .in_free        (mag_free),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_edge_res   (rsp_edge_res),
      .rsp_grey_level (rsp_grey_level),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule
